// File: src/gwwb_pkg.sv
`default_nettype none

package gwwb_pkg;

  // Pixel and gain formats
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned TOTAL_W   = 30;
  localparam int unsigned ALL_W     = 32;
  localparam int unsigned GAIN_W    = 25;
  localparam int unsigned PROD_W    = PIX_W + GAIN_W;

  // Divider formats: dividend is the sum of all channel totals shifted by the fraction width
  localparam int unsigned DVD_W     = ALL_W + FRAC_W;
  localparam int unsigned DSR_W     = 32;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(1) << FRAC_W;
  localparam logic [GAIN_W-1:0]  GAIN_CLAMP = GAIN_W'(256) << FRAC_W;
  localparam logic [PIX_W-1:0]   PIX_MAX    = {PIX_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  gather;
    logic  apply_in;
    logic  load;
    logic  div_start;
    logic  gain_wr;
    logic  apply_held;
    chan_e chan;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pending;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

// File: src/gray_world_white_balance.sv
// Gray-world white balance on 8-bit RGB pixels.
// Request channel: a request is taken at a rising edge with start_i high and
// busy_o low. mode_i = 0 gathers the pixel into per-channel running sums
// (saturating at 2^30-1); mode_i = 1 corrects the pixel with the gains in force.
// Result channel: valid_o is high for exactly one cycle with red_out_o,
// green_out_o and blue_out_o; the receiver takes it in that cycle and cannot stall.
// Gather requests produce no result; busy_o stays low.
// A correct request with no gather since the last gain update gives its result
// in the cycle after acceptance; busy_o stays low, one request per cycle.
// The first correct request after any gather computes three Q9.16 gains with
// a shared restoring divider, one quotient bit per cycle, one channel after
// another: busy_o is high while the gains are computed, and the result strobes
// after all three gains are written. The gathered sums are then cleared.
// Reset: sums clear, all gains become 1.0, no result is pending.
`default_nettype none

module gray_world_white_balance (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  output logic                        busy_o,
  input  wire                         mode_i,
  input  wire  [gwwb_pkg::PIX_W-1:0]  red_i,
  input  wire  [gwwb_pkg::PIX_W-1:0]  green_i,
  input  wire  [gwwb_pkg::PIX_W-1:0]  blue_i,
  output logic                        valid_o,
  output logic [gwwb_pkg::PIX_W-1:0]  red_out_o,
  output logic [gwwb_pkg::PIX_W-1:0]  green_out_o,
  output logic [gwwb_pkg::PIX_W-1:0]  blue_out_o
);

  gwwb_pkg::cmd_t  cmd;
  gwwb_pkg::stat_t stat;

  gwwb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  gwwb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .valid_o     (valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

endmodule

`default_nettype wire

// File: src/gwwb_div.sv
`default_nettype none

module gwwb_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [gwwb_pkg::DVD_W-1:0]     dividend_i,
  input  wire  [gwwb_pkg::DSR_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [gwwb_pkg::GAIN_W-1:0]    gain_o
);

  logic [gwwb_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [gwwb_pkg::DSR_W-1:0]  dsr_q, dsr_d;
  logic [gwwb_pkg::DSR_W-1:0]  rem_q, rem_d;
  logic [gwwb_pkg::GAIN_W-1:0] quo_q, quo_d;
  logic                        ovf_q, ovf_d;
  logic [gwwb_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [gwwb_pkg::DSR_W:0]    rem_sh;
  logic [gwwb_pkg::DSR_W:0]    rem_sub;
  logic                        fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[gwwb_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
      ovf_d = 1'b0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[gwwb_pkg::DVD_W-2:0], 1'b0};
      rem_d = fits ? rem_sub[gwwb_pkg::DSR_W-1:0] : rem_sh[gwwb_pkg::DSR_W-1:0];
      // Quotient bits above the gain width only mark an overflow
      quo_d = {quo_q[gwwb_pkg::GAIN_W-2:0], fits};
      ovf_d = ovf_q | quo_q[gwwb_pkg::GAIN_W-1];
      cnt_d = cnt_q + gwwb_pkg::CNT_W'(1);
      if (cnt_q == gwwb_pkg::CNT_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  // Clamp; a zero divisor yields an all-ones quotient and so clamps too
  assign done_o = done_q;
  assign gain_o = (ovf_q || (quo_q > gwwb_pkg::GAIN_CLAMP)) ? gwwb_pkg::GAIN_CLAMP : quo_q;

endmodule

`default_nettype wire

// File: src/gwwb_dpath.sv
`default_nettype none

module gwwb_dpath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  gwwb_pkg::cmd_t          cmd_i,
  output gwwb_pkg::stat_t               stat_o,
  input  wire  [gwwb_pkg::PIX_W-1:0]    red_i,
  input  wire  [gwwb_pkg::PIX_W-1:0]    green_i,
  input  wire  [gwwb_pkg::PIX_W-1:0]    blue_i,
  output logic                          valid_o,
  output logic [gwwb_pkg::PIX_W-1:0]    red_out_o,
  output logic [gwwb_pkg::PIX_W-1:0]    green_out_o,
  output logic [gwwb_pkg::PIX_W-1:0]    blue_out_o
);

  logic [gwwb_pkg::TOTAL_W-1:0] red_tot_q, green_tot_q, blue_tot_q;
  logic [gwwb_pkg::GAIN_W-1:0]  red_gain_q, green_gain_q, blue_gain_q;
  logic                         pending_q;
  logic [gwwb_pkg::ALL_W-1:0]   all_q;
  logic [gwwb_pkg::PIX_W-1:0]   red_pix_q, green_pix_q, blue_pix_q;
  logic                         valid_q;
  logic [gwwb_pkg::PIX_W-1:0]   red_out_q, green_out_q, blue_out_q;

  logic [gwwb_pkg::ALL_W-1:0]   all_sum;
  logic [gwwb_pkg::TOTAL_W-1:0] chan_tot;
  logic [gwwb_pkg::DSR_W-1:0]   den;
  logic                         div_done;
  logic [gwwb_pkg::GAIN_W-1:0]  div_gain;
  logic [gwwb_pkg::PIX_W-1:0]   red_src, green_src, blue_src;

  function automatic logic [gwwb_pkg::TOTAL_W-1:0] sat_add(
    input logic [gwwb_pkg::TOTAL_W-1:0] tot,
    input logic [gwwb_pkg::PIX_W-1:0]   px
  );
    logic [gwwb_pkg::TOTAL_W:0] s;
    s = {1'b0, tot} + (gwwb_pkg::TOTAL_W+1)'(px);
    return s[gwwb_pkg::TOTAL_W] ? gwwb_pkg::TOTAL_MAX : s[gwwb_pkg::TOTAL_W-1:0];
  endfunction

  function automatic logic [gwwb_pkg::PIX_W-1:0] apply_gain(
    input logic [gwwb_pkg::PIX_W-1:0]  px,
    input logic [gwwb_pkg::GAIN_W-1:0] gain
  );
    logic [gwwb_pkg::PROD_W-1:0]                 prod;
    logic [gwwb_pkg::PROD_W-gwwb_pkg::FRAC_W-1:0] v;
    prod = gwwb_pkg::PROD_W'(px) * gwwb_pkg::PROD_W'(gain);
    v    = prod[gwwb_pkg::PROD_W-1:gwwb_pkg::FRAC_W];
    return (v > (gwwb_pkg::PROD_W-gwwb_pkg::FRAC_W)'(gwwb_pkg::PIX_MAX))
           ? gwwb_pkg::PIX_MAX : v[gwwb_pkg::PIX_W-1:0];
  endfunction

  // Sum of all three channel totals
  assign all_sum = gwwb_pkg::ALL_W'(red_tot_q) + gwwb_pkg::ALL_W'(green_tot_q)
                 + gwwb_pkg::ALL_W'(blue_tot_q);

  // Select the channel under division and form three times its total
  always_comb begin
    case (cmd_i.chan)
      gwwb_pkg::CH_RED:   chan_tot = red_tot_q;
      gwwb_pkg::CH_GREEN: chan_tot = green_tot_q;
      gwwb_pkg::CH_BLUE:  chan_tot = blue_tot_q;
      default:            chan_tot = blue_tot_q;
    endcase
  end

  assign den = gwwb_pkg::DSR_W'({chan_tot, 1'b0}) + gwwb_pkg::DSR_W'(chan_tot);

  gwwb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({all_q, {gwwb_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (den),
    .done_o     (div_done),
    .gain_o     (div_gain)
  );

  // Statistics and gain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_tot_q    <= '0;
      green_tot_q  <= '0;
      blue_tot_q   <= '0;
      red_gain_q   <= gwwb_pkg::GAIN_ONE;
      green_gain_q <= gwwb_pkg::GAIN_ONE;
      blue_gain_q  <= gwwb_pkg::GAIN_ONE;
      pending_q    <= 1'b0;
    end else begin
      if (cmd_i.gather) begin
        red_tot_q   <= sat_add(red_tot_q, red_i);
        green_tot_q <= sat_add(green_tot_q, green_i);
        blue_tot_q  <= sat_add(blue_tot_q, blue_i);
        pending_q   <= 1'b1;
      end
      if (cmd_i.gain_wr) begin
        case (cmd_i.chan)
          gwwb_pkg::CH_RED:   red_gain_q   <= div_gain;
          gwwb_pkg::CH_GREEN: green_gain_q <= div_gain;
          gwwb_pkg::CH_BLUE:  blue_gain_q  <= div_gain;
          default:            blue_gain_q  <= blue_gain_q;
        endcase
      end
      // Drop the gathered statistics once the gains are in force
      if (cmd_i.apply_held) begin
        red_tot_q   <= '0;
        green_tot_q <= '0;
        blue_tot_q  <= '0;
        pending_q   <= 1'b0;
      end
    end
  end

  // Hold the request pixel and total sum while gains are computed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      all_q       <= all_sum;
      red_pix_q   <= red_i;
      green_pix_q <= green_i;
      blue_pix_q  <= blue_i;
    end
  end

  assign red_src   = cmd_i.apply_held ? red_pix_q   : red_i;
  assign green_src = cmd_i.apply_held ? green_pix_q : green_i;
  assign blue_src  = cmd_i.apply_held ? blue_pix_q  : blue_i;

  // Output register: one-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.apply_in | cmd_i.apply_held;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_in || cmd_i.apply_held) begin
      red_out_q   <= apply_gain(red_src, red_gain_q);
      green_out_q <= apply_gain(green_src, green_gain_q);
      blue_out_q  <= apply_gain(blue_src, blue_gain_q);
    end
  end

  assign stat_o.pending  = pending_q;
  assign stat_o.div_done = div_done;
  assign valid_o     = valid_q;
  assign red_out_o   = red_out_q;
  assign green_out_o = green_out_q;
  assign blue_out_o  = blue_out_q;

endmodule

`default_nettype wire

// File: src/gwwb_ctrl.sv
`default_nettype none

module gwwb_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire              mode_i,
  input  wire gwwb_pkg::stat_t stat_i,
  output gwwb_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_DIV   = 2'd2,
    ST_APPLY = 2'd3
  } state_e;

  state_e          state_q, state_d;
  gwwb_pkg::chan_e chan_q, chan_d;
  logic            busy_q;
  logic            accept;

  assign accept = start_i & ~busy_q;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.chan = chan_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            cmd_o.gather = 1'b1;
          end else if (!stat_i.pending) begin
            cmd_o.apply_in = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            chan_d     = gwwb_pkg::CH_RED;
            state_d    = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.gain_wr = 1'b1;
          case (chan_q)
            gwwb_pkg::CH_RED: begin
              chan_d  = gwwb_pkg::CH_GREEN;
              state_d = ST_START;
            end
            gwwb_pkg::CH_GREEN: begin
              chan_d  = gwwb_pkg::CH_BLUE;
              state_d = ST_START;
            end
            default: begin
              state_d = ST_APPLY;
            end
          endcase
        end
      end
      ST_APPLY: begin
        cmd_o.apply_held = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, channel and the registered busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= gwwb_pkg::CH_RED;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire
